// ===== src/chained_hash_find_or_insert_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the hash table engine (chfi_engine)
// ---------------------------------------------------------------------------
`ifndef CHAINED_HASH_FIND_OR_INSERT_DEFINES_SVH
`define CHAINED_HASH_FIND_OR_INSERT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CHFI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define CHFI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/chfi_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chfi_pkg
// Types and sizing constants for the chained hash find-or-insert block.
// ---------------------------------------------------------------------------
package chfi_pkg;

  localparam int ENTRIES    = 64;
  localparam int SLOTS      = 16;
  localparam int VALUE_BITS = 16;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int STEP_W = $clog2(ENTRIES + 1);

  localparam int HASH_W   = 32;
  localparam int INVAL_W  = 16;
  localparam int OUTVAL_W = 16;
  localparam int SLOTID_W = 6;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_DEFINE = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDEF = 2'd1,
    ST_DUP   = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_FIND,
    OP_DEFINE,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef enum logic [3:0] {
    ES_IDLE,
    ES_CLEAR,
    ES_WALK,
    ES_CMP,
    ES_ALLOC,
    ES_POP,
    ES_ACT,
    ES_VAL,
    ES_RESULT
  } eng_state_t;

  typedef struct packed {
    mode_t                mode;
    logic [HASH_W-1:0]    name_hash;
    logic [INVAL_W-1:0]   value;
  } in_t;

  typedef struct packed {
    status_t              status;
    logic [OUTVAL_W-1:0]  found_value;
    logic [SLOTID_W-1:0]  entry_slot;
  } out_t;

  typedef struct packed {
    op_t                   op;
    logic [SLOT_W-1:0]     slot;
    logic [HASH_W-1:0]     hash;
    logic [VALUE_BITS-1:0] value;
  } cmd_t;

endpackage

// ===== src/chained_hash_find_or_insert.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chained_hash_find_or_insert
// Find-or-insert of 32-bit name hashes in a chained hash table with a free list.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per request {mode, name_hash, value}; lookup,
//           define or clear of the whole table (mode three is a no-op).
//   out_* : exactly one result per request {status, found_value, entry_slot},
//           in request order.
//   Both channels are valid/ready; a transaction moves when both are high.
// Timing:
//   An input register and a two-deep command queue feed the table engine, so
//   requests keep being taken while the engine works or a result waits.
//   Engine time per request grows with the number of other chain entries walked
//   before a hit (a lookup hit adds a value read); a miss walks the whole
//   chain, and a full table skips the free-list pop.
//   Each chain step is one memory read and one compare.
// Reset / stall:
//   rst_n (synchronous) empties the table at once: no chains, entry 1 at the
//   free list head, nothing defined. A stalled out_ready holds the result
//   register; the engine stops at its next result and the queue fills.
// ---------------------------------------------------------------------------
module chained_hash_find_or_insert (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  chfi_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output chfi_pkg::out_t  out_data
);

  logic           fr_valid, fr_ready;
  chfi_pkg::cmd_t fr_cmd;
  logic           q_valid, q_ready;
  chfi_pkg::cmd_t q_cmd;

  chfi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (fr_valid),
    .cmd_ready (fr_ready),
    .cmd       (fr_cmd)
  );

  chfi_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  chfi_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== src/chfi_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chfi_front
// Input stage: takes a transaction, decodes the mode and picks the slot.
// ---------------------------------------------------------------------------
module chfi_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  chfi_pkg::in_t   in_data,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output chfi_pkg::cmd_t  cmd
);

  logic           vld_r, vld_nxt;
  chfi_pkg::cmd_t cmd_r, cmd_nxt;
  chfi_pkg::cmd_t decoded;

  always_comb begin
    case (in_data.mode)
      chfi_pkg::MODE_LOOKUP: decoded.op = chfi_pkg::OP_FIND;
      chfi_pkg::MODE_DEFINE: decoded.op = chfi_pkg::OP_DEFINE;
      chfi_pkg::MODE_CLEAR:  decoded.op = chfi_pkg::OP_CLEAR;
      default:               decoded.op = chfi_pkg::OP_NOP;
    endcase
    decoded.slot  = chfi_pkg::SLOT_W'(in_data.name_hash &
                                      chfi_pkg::HASH_W'(chfi_pkg::SLOTS - 1));
    decoded.hash  = in_data.name_hash;
    decoded.value = chfi_pkg::VALUE_BITS'(in_data.value);
  end

  assign in_ready  = !vld_r || cmd_ready;
  assign cmd_valid = vld_r;
  assign cmd       = cmd_r;

  always_comb begin
    vld_nxt = in_ready ? in_valid : vld_r;
    cmd_nxt = (in_valid && in_ready) ? decoded : cmd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    cmd_r <= cmd_nxt;
  end

endmodule

// ===== src/chfi_fifo.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chfi_fifo
// Short command queue between the input stage and the table engine.
// ---------------------------------------------------------------------------
module chfi_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  chfi_pkg::cmd_t  push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output chfi_pkg::cmd_t  pop_data
);

  chfi_pkg::cmd_t                   mem_r [chfi_pkg::FIFO_DEPTH];
  logic [chfi_pkg::FIFO_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [chfi_pkg::FIFO_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [chfi_pkg::FIFO_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                             do_push, do_pop;

  assign push_ready = (cnt_r != chfi_pkg::FIFO_CNT_W'(chfi_pkg::FIFO_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == chfi_pkg::FIFO_PTR_W'(chfi_pkg::FIFO_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == chfi_pkg::FIFO_PTR_W'(chfi_pkg::FIFO_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/chfi_engine.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chfi_engine
// Table engine: walks a slot chain, pops the free list on a miss, applies
// lookup / define / clear and holds the result in an output register.
// ---------------------------------------------------------------------------
`include "chained_hash_find_or_insert_defines.svh"

module chfi_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  chfi_pkg::cmd_t  cmd,
  output logic            out_valid,
  input  logic            out_ready,
  output chfi_pkg::out_t  out_data
);

  localparam int IW = chfi_pkg::IDX_W;

  chfi_pkg::eng_state_t            state_r, state_nxt;
  chfi_pkg::cmd_t                  cmd_r, cmd_nxt;
  logic [IW-1:0]                   idx_r, idx_nxt;
  logic [chfi_pkg::STEP_W-1:0]     steps_r, steps_nxt;
  logic [IW-1:0]                   free_head_r, free_head_nxt;
  logic [IW-1:0]                   chain_heads_r [chfi_pkg::SLOTS];
  logic [chfi_pkg::ENTRIES-1:0]    defined_r;
  logic [chfi_pkg::ENTRIES-1:0]    link_vld_r;
  chfi_pkg::status_t               res_status_r, res_status_nxt;
  logic [chfi_pkg::OUTVAL_W-1:0]   res_value_r, res_value_nxt;
  logic                            out_valid_r, out_valid_nxt;
  chfi_pkg::out_t                  out_data_r;

  // table memories
  logic [chfi_pkg::HASH_W-1:0]     hash_mem [chfi_pkg::ENTRIES];
  logic [IW-1:0]                   link_mem [chfi_pkg::ENTRIES];
  logic [chfi_pkg::VALUE_BITS-1:0] val_mem  [chfi_pkg::ENTRIES];

  logic [IW-1:0]                   rd_addr;
  logic [chfi_pkg::HASH_W-1:0]     hash_q;
  logic [IW-1:0]                   link_q, link_addr_q;
  logic                            link_vld_q;
  logic [chfi_pkg::VALUE_BITS-1:0] val_q;
  logic [IW-1:0]                   link_rd;

  logic                            clear_all, load_out;
  logic                            link_we, hash_we, val_we, head_we, def_set;

  // an entry whose link was never rewritten still points at its successor
  assign link_rd = link_vld_q ? link_q :
                   (link_addr_q == IW'(chfi_pkg::ENTRIES - 1)) ? '0 : link_addr_q + 1'b1;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    steps_nxt      = steps_r;
    free_head_nxt  = free_head_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    cmd_ready      = 1'b0;
    rd_addr        = idx_r;
    clear_all      = 1'b0;
    load_out       = 1'b0;
    link_we        = 1'b0;
    hash_we        = 1'b0;
    val_we         = 1'b0;
    head_we        = 1'b0;
    def_set        = 1'b0;

    case (state_r)
      chfi_pkg::ES_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd_nxt        = cmd;
          res_status_nxt = chfi_pkg::ST_OK;
          res_value_nxt  = '0;
          idx_nxt        = '0;
          steps_nxt      = '0;
          case (cmd.op)
            chfi_pkg::OP_CLEAR: state_nxt = chfi_pkg::ES_CLEAR;
            chfi_pkg::OP_NOP:   state_nxt = chfi_pkg::ES_RESULT;
            default: begin
              idx_nxt   = chain_heads_r[cmd.slot];
              state_nxt = chfi_pkg::ES_WALK;
            end
          endcase
        end
      end
      chfi_pkg::ES_CLEAR: begin
        clear_all = 1'b1;
        state_nxt = chfi_pkg::ES_RESULT;
      end
      chfi_pkg::ES_WALK: begin
        if (idx_r == '0 || steps_r == chfi_pkg::STEP_W'(chfi_pkg::ENTRIES)) begin
          state_nxt = chfi_pkg::ES_ALLOC;
        end else begin
          state_nxt = chfi_pkg::ES_CMP;
        end
      end
      chfi_pkg::ES_CMP: begin
        if (hash_q == cmd_r.hash) begin
          state_nxt = chfi_pkg::ES_ACT;
        end else begin
          idx_nxt   = link_rd;
          steps_nxt = steps_r + 1'b1;
          state_nxt = chfi_pkg::ES_WALK;
        end
      end
      chfi_pkg::ES_ALLOC: begin
        rd_addr = free_head_r;
        if (free_head_r == '0) begin
          res_status_nxt = chfi_pkg::ST_FULL;
          idx_nxt        = '0;
          state_nxt      = chfi_pkg::ES_RESULT;
        end else begin
          state_nxt = chfi_pkg::ES_POP;
        end
      end
      chfi_pkg::ES_POP: begin
        // pop free head and push it at the front of the slot chain
        free_head_nxt = link_rd;
        link_we       = 1'b1;
        hash_we       = 1'b1;
        head_we       = 1'b1;
        idx_nxt       = free_head_r;
        state_nxt     = chfi_pkg::ES_ACT;
      end
      chfi_pkg::ES_ACT: begin
        state_nxt = chfi_pkg::ES_RESULT;
        if (defined_r[idx_r]) begin
          if (cmd_r.op == chfi_pkg::OP_FIND) begin
            state_nxt = chfi_pkg::ES_VAL;
          end else begin
            res_status_nxt = chfi_pkg::ST_DUP;
          end
        end else if (cmd_r.op == chfi_pkg::OP_FIND) begin
          res_status_nxt = chfi_pkg::ST_UNDEF;
        end else begin
          val_we  = 1'b1;
          def_set = 1'b1;
        end
      end
      chfi_pkg::ES_VAL: begin
        res_value_nxt = chfi_pkg::OUTVAL_W'(val_q);
        state_nxt     = chfi_pkg::ES_RESULT;
      end
      chfi_pkg::ES_RESULT: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = chfi_pkg::ES_IDLE;
        end
      end
      default: state_nxt = chfi_pkg::ES_IDLE;
    endcase

    out_valid_nxt = (out_valid_r && !out_ready) || load_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chfi_pkg::ES_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // table control state: reset and clear command restore the initial table
  always_ff @(posedge clk) begin
    if (!rst_n || clear_all) begin
      free_head_r <= IW'(1);
      defined_r   <= '0;
      link_vld_r  <= '0;
      for (int s = 0; s < chfi_pkg::SLOTS; s++) begin
        chain_heads_r[s] <= '0;
      end
    end else begin
      free_head_r <= free_head_nxt;
      if (def_set) begin
        defined_r[idx_r] <= 1'b1;
      end
      if (link_we) begin
        link_vld_r[free_head_r] <= 1'b1;
      end
      if (head_we) begin
        chain_heads_r[cmd_r.slot] <= free_head_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    idx_r        <= idx_nxt;
    steps_r      <= steps_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    if (load_out) begin
      out_data_r.status      <= res_status_r;
      out_data_r.found_value <= res_value_r;
      out_data_r.entry_slot  <= chfi_pkg::SLOTID_W'(idx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (hash_we) begin
      hash_mem[free_head_r] <= cmd_r.hash;
    end
    hash_q <= hash_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[free_head_r] <= chain_heads_r[cmd_r.slot];
    end
    link_q      <= link_mem[rd_addr];
    link_addr_q <= rd_addr;
    link_vld_q  <= link_vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[idx_r] <= cmd_r.value;
    end
    val_q <= val_mem[rd_addr];
  end

  `CHFI_ASSERT_NOW(a_pop_not_sentinel, state_r == chfi_pkg::ES_POP, free_head_r != '0, "free list handed out the sentinel entry")
  `CHFI_ASSERT_NEXT(a_pop_to_act, state_r == chfi_pkg::ES_POP, state_r == chfi_pkg::ES_ACT && idx_r != '0, "reserved entry not applied")
  `CHFI_ASSERT_NOW(a_act_real_entry, state_r == chfi_pkg::ES_ACT, idx_r != '0, "action on the sentinel entry")
  `CHFI_ASSERT_NOW(a_walk_bounded, state_r == chfi_pkg::ES_WALK, steps_r <= chfi_pkg::STEP_W'(chfi_pkg::ENTRIES), "chain walk overran its bound")
  `CHFI_ASSERT_NOW(a_full_no_slot, state_r == chfi_pkg::ES_RESULT && res_status_r == chfi_pkg::ST_FULL, idx_r == '0, "full result carries an entry")

endmodule
